[design/dcc_pkg.sv]
// dcc_pkg: shared types, opcodes and sizing constants for the distinct color counter
// depends on nothing; imported by the controller, the datapath and the top level
`default_nettype none

package dcc_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int COLOR_W     = 32;
   localparam int COUNT_W     = 16;

   localparam logic [1:0] OP_COUNT = 2'd0;
   localparam logic [1:0] OP_DUMP  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   typedef struct packed {
      logic [1:0]         opcode;
      logic [COLOR_W-1:0] pixel_color;
   } req_type;

   typedef struct packed {
      logic [COLOR_W-1:0] entry_color;
      logic [COUNT_W-1:0] entry_count;
      logic               last_entry;
      logic               table_empty;
      logic               overflowed;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load_req;
      logic idx_clear;
      logic idx_inc;
      logic mem_read;
      logic write_new;
      logic write_inc;
      logic set_ovf;
      logic clear_table;
      logic out_load_entry;
      logic out_load_empty;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic scan_done;
      logic match;
      logic full;
      logic table_zero;
      logic out_free;
   } sts_type;

endpackage

`default_nettype wire

[design/dcc_ctrl.sv]
// dcc_ctrl: sequencing state machine for count, dump and clear requests
// depends on dcc_pkg; drives the command struct of dcc_datapath
`default_nettype none

module dcc_ctrl (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_ready,
   input  wire [1:0]         req_opcode,
   input  dcc_pkg::sts_type  sts,
   output dcc_pkg::cmd_type  cmd
);
   import dcc_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SCAN  = 3'd1;
   localparam logic [2:0] S_CMP   = 3'd2;
   localparam logic [2:0] S_DSCAN = 3'd3;
   localparam logic [2:0] S_DOUT  = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_ready = (state_ff == S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req  = 1'b1;
               cmd.idx_clear = 1'b1;
               unique case (req_opcode)
                  OP_COUNT: state_in = S_SCAN;
                  OP_DUMP:  state_in = S_DSCAN;
                  OP_CLEAR: cmd.clear_table = 1'b1;
                  default:  state_in = S_IDLE;
               endcase
            end
         end
         S_SCAN: begin
            if (sts.scan_done) begin
               // no match among stored entries: append or flag overflow
               if (sts.full) begin
                  cmd.set_ovf = 1'b1;
               end else begin
                  cmd.write_new = 1'b1;
               end
               state_in = S_IDLE;
            end else begin
               cmd.mem_read = 1'b1;
               state_in     = S_CMP;
            end
         end
         S_CMP: begin
            if (sts.match) begin
               cmd.write_inc = 1'b1;
               state_in      = S_IDLE;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = S_SCAN;
            end
         end
         S_DSCAN: begin
            if (sts.table_zero) begin
               if (sts.out_free) begin
                  cmd.out_load_empty = 1'b1;
                  state_in           = S_IDLE;
               end
            end else if (sts.scan_done) begin
               state_in = S_IDLE;
            end else begin
               cmd.mem_read = 1'b1;
               state_in     = S_DOUT;
            end
         end
         S_DOUT: begin
            if (sts.out_free) begin
               cmd.out_load_entry = 1'b1;
               cmd.idx_inc        = 1'b1;
               state_in           = S_DSCAN;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

[design/dcc_datapath.sv]
// dcc_datapath: color and count memories, scan index, fill count and result register
// depends on dcc_pkg; steered by the command struct from dcc_ctrl
`default_nettype none

module dcc_datapath (
   input  wire               clock,
   input  wire               reset,
   input  dcc_pkg::req_type  req_data,
   input  dcc_pkg::cmd_type  cmd,
   output dcc_pkg::sts_type  sts,
   output logic              rsp_valid,
   input  wire               rsp_ready,
   output dcc_pkg::rsp_type  rsp_data
);
   import dcc_pkg::*;

   logic [COLOR_W-1:0] color_mem [TABLE_DEPTH];
   logic [COUNT_W-1:0] count_mem [TABLE_DEPTH];

   logic [CNT_W-1:0]   used_ff, used_in;
   logic               ovf_ff, ovf_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic [COLOR_W-1:0] color_q_ff;
   logic [COLOR_W-1:0] rd_color_ff;
   logic [COUNT_W-1:0] rd_count_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff;

   logic [IDX_W-1:0]   rd_addr;
   logic [IDX_W-1:0]   wr_addr;
   logic               wr_en;
   logic [COLOR_W-1:0] wr_color;
   logic [COUNT_W-1:0] wr_count;
   logic [CNT_W-1:0]   idx_next;

   assign rd_addr  = idx_ff[IDX_W-1:0];
   assign idx_next = idx_ff + CNT_W'(1);

   // one write port: append a new color, or bump the count of a match
   always_comb begin
      wr_en    = cmd.write_new | cmd.write_inc;
      wr_addr  = cmd.write_new ? used_ff[IDX_W-1:0] : idx_ff[IDX_W-1:0];
      wr_color = color_q_ff;
      if (cmd.write_new) begin
         wr_count = COUNT_W'(1);
      end else if (rd_count_ff == {COUNT_W{1'b1}}) begin
         wr_count = rd_count_ff;
      end else begin
         wr_count = rd_count_ff + COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         count_mem[wr_addr] <= wr_count;
         if (cmd.write_new) begin
            color_mem[wr_addr] <= wr_color;
         end
      end
      if (cmd.mem_read) begin
         rd_color_ff <= color_mem[rd_addr];
         rd_count_ff <= count_mem[rd_addr];
      end
      if (cmd.load_req) begin
         color_q_ff <= req_data.pixel_color;
      end
   end

   always_comb begin
      used_in = used_ff;
      ovf_in  = ovf_ff;
      if (cmd.clear_table) begin
         used_in = '0;
         ovf_in  = 1'b0;
      end else if (cmd.write_new) begin
         used_in = used_ff + CNT_W'(1);
      end else if (cmd.set_ovf) begin
         ovf_in = 1'b1;
      end
      idx_in = idx_ff;
      if (cmd.idx_clear) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_next;
      end
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load_entry || cmd.out_load_empty) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         ovf_ff       <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         used_ff      <= used_in;
         ovf_ff       <= ovf_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load_empty) begin
         rsp_data_ff <= '{entry_color: '0, entry_count: '0, last_entry: 1'b0,
                          table_empty: 1'b1, overflowed: 1'b0};
      end else if (cmd.out_load_entry) begin
         rsp_data_ff <= '{entry_color: rd_color_ff, entry_count: rd_count_ff,
                          last_entry: (idx_next == used_ff), table_empty: 1'b0,
                          overflowed: ovf_ff};
      end
   end

   assign sts.scan_done  = (idx_ff == used_ff);
   assign sts.match      = (rd_color_ff == color_q_ff);
   assign sts.full       = (used_ff == CNT_W'(TABLE_DEPTH));
   assign sts.table_zero = (used_ff == '0);
   assign sts.out_free   = ~rsp_valid_ff | rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

[design/distinct_color_counter.sv]
// distinct_color_counter: top level joining the request controller and the table datapath
// depends on dcc_pkg, dcc_ctrl and dcc_datapath
//
//   channel   direction  handshake              payload
//   request   in         req_valid / req_ready  req_data  (opcode, pixel_color)
//   response  out        rsp_valid / rsp_ready  rsp_data  (entry_color .. overflowed)
//
// one request at a time; req_ready is high only between requests
// count: stored entries are checked serially through one memory read port (SCAN reads, CMP compares),
//   and the color is appended when no stored entry matches it
// dump: each entry is read in DSCAN and then loaded in DOUT, each entry waits on the output register
// clear and unknown opcodes are handled without leaving IDLE; reset empties the table and clears overflow
`default_nettype none

module distinct_color_counter (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_ready,
   input  dcc_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  wire               rsp_ready,
   output dcc_pkg::rsp_type  rsp_data
);
   import dcc_pkg::*;

   cmd_type cmd;
   sts_type sts;

   dcc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_opcode (req_data.opcode),
      .sts        (sts),
      .cmd        (cmd)
   );

   dcc_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // never append into a full table
   assert property (@(posedge clock) disable iff (reset) cmd.write_new |-> !sts.full)
      else $error("append issued with table full");

   // at most one table update per cycle
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.write_new, cmd.write_inc, cmd.set_ovf, cmd.clear_table}))
      else $error("conflicting table updates");

   // a waiting response is never overwritten
   assert property (@(posedge clock) disable iff (reset)
      (cmd.out_load_entry || cmd.out_load_empty) |-> sts.out_free)
      else $error("response register overwritten");

   // requests only enter while the controller is idle
   assert property (@(posedge clock) disable iff (reset)
      cmd.load_req |-> (req_valid && req_ready))
      else $error("request loaded without handshake");

endmodule

`default_nettype wire
